// File: rtl/core/pkcc_pkg.sv
// shared constants, types and codes for the per-key connection counter
`default_nettype none

package pkcc_pkg;

    localparam int ENTRIES      = 64;
    localparam int COUNT_BITS   = 16;
    localparam int ADDR_W       = 32;
    localparam int OPEN_COUNT_W = 16;
    localparam int STATUS_W     = 2;
    localparam int IDX_W        = $clog2(ENTRIES);
    localparam int CNT_EXT_W    = (COUNT_BITS > OPEN_COUNT_W) ? COUNT_BITS : OPEN_COUNT_W;

    localparam logic OP_OPEN    = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0]     address;
        logic [COUNT_BITS-1:0] count;
    } entry_t;

    typedef struct packed {
        logic                  done;
        logic                  hit;
        logic [IDX_W-1:0]      hit_idx;
        logic [COUNT_BITS-1:0] hit_count;
        logic                  free_found;
        logic [IDX_W-1:0]      free_idx;
    } scan_res_t;

endpackage

`default_nettype wire

// File: rtl/core/pkcc_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module pkcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: rtl/core/pkcc_scan.sv
// table scan sequencer: walks the entries through one shared key compare
`default_nettype none

module pkcc_scan (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic [pkcc_pkg::ADDR_W-1:0]       key,
    input  wire logic [pkcc_pkg::ENTRIES-1:0]      valid_vec,
    input  wire pkcc_pkg::entry_t                  rd_data,
    output logic      [pkcc_pkg::IDX_W-1:0]        rd_addr,
    output pkcc_pkg::scan_res_t                    res
);
    import pkcc_pkg::*;

    logic                  busy_reg, busy_next;
    logic [IDX_W:0]        scan_idx_reg, scan_idx_next;
    logic                  cmp_pend_reg, cmp_pend_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                  done_reg, done_next;
    logic                  hit_reg, hit_next;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic [COUNT_BITS-1:0] hit_count_reg, hit_count_next;
    logic                  free_found_reg, free_found_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;

    logic cmp_valid;
    logic match;

    assign cmp_valid = valid_vec[cmp_idx_reg];
    assign match     = cmp_valid && (rd_data.address == key);
    assign rd_addr   = scan_idx_reg[IDX_W-1:0];

    always_comb begin
        busy_next       = busy_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_pend_next   = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        done_next       = 1'b0;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_count_next  = hit_count_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;

        if (start) begin
            busy_next       = 1'b1;
            scan_idx_next   = '0;
            hit_next        = 1'b0;
            free_found_next = 1'b0;
        end else if (busy_reg) begin
            // issue the next read while the previous entry is compared
            if (scan_idx_reg < (IDX_W+1)'(ENTRIES)) begin
                cmp_pend_next = 1'b1;
                cmp_idx_next  = scan_idx_reg[IDX_W-1:0];
                scan_idx_next = scan_idx_reg + (IDX_W+1)'(1);
            end
            if (cmp_pend_reg) begin
                if (match) begin
                    hit_next       = 1'b1;
                    hit_idx_next   = cmp_idx_reg;
                    hit_count_next = rd_data.count;
                    busy_next      = 1'b0;
                    cmp_pend_next  = 1'b0;
                    done_next      = 1'b1;
                end else begin
                    // lowest free slot wins
                    if (!cmp_valid && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = cmp_idx_reg;
                    end
                    if (cmp_idx_reg == IDX_W'(ENTRIES-1)) begin
                        busy_next     = 1'b0;
                        cmp_pend_next = 1'b0;
                        done_next     = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            scan_idx_reg   <= '0;
            cmp_pend_reg   <= 1'b0;
            done_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            scan_idx_reg   <= scan_idx_next;
            cmp_pend_reg   <= cmp_pend_next;
            done_reg       <= done_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
        end
        cmp_idx_reg   <= cmp_idx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_count_reg <= hit_count_next;
        free_idx_reg  <= free_idx_next;
    end

    assign res = {done_reg, hit_reg, hit_idx_reg, hit_count_reg, free_found_reg, free_idx_reg};

endmodule

`default_nettype wire

// File: rtl/core/per_key_connection_counter_core.sv
// per-key connection counter: table of client addresses with open-connection counts
// scan: an accepted beat walks the table one entry per cycle, stopping at the first hit;
//   the scan is followed by ST_UPDATE, and the result beat is then valid in ST_OUT
// items: one at a time; a new beat is taken only in ST_IDLE, after the result beat is taken,
//   and the table is walked through the single read port of the entry ram feeding one key compare
// reset: synchronous active-low; clears all valid marks at once, address/count ram is not cleared
`default_nettype none

module per_key_connection_counter_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_op,
    input  wire logic [pkcc_pkg::ADDR_W-1:0]         s_client_address,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [pkcc_pkg::OPEN_COUNT_W-1:0]   m_open_count,
    output logic      [pkcc_pkg::STATUS_W-1:0]       m_status
);
    import pkcc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_OUT
    } state_t;

    state_t                  state_reg, state_next;
    logic                    op_reg, op_next;
    logic [ADDR_W-1:0]       key_reg, key_next;
    logic [ENTRIES-1:0]      valid_reg, valid_next;
    logic                    m_valid_reg, m_valid_next;
    logic [OPEN_COUNT_W-1:0] m_open_count_reg, m_open_count_next;
    logic [STATUS_W-1:0]     m_status_reg, m_status_next;

    logic                  start;
    scan_res_t             scan_res;
    logic [IDX_W-1:0]      rd_addr;
    entry_t                rd_data;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    entry_t                wr_data;
    logic [COUNT_BITS-1:0] new_count;
    logic [CNT_EXT_W-1:0]  new_count_ext;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    assign s_ready = (state_reg == ST_IDLE);
    assign start   = s_valid && s_ready;

    pkcc_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .key       (key_reg),
        .valid_vec (valid_reg),
        .rd_data   (rd_data),
        .rd_addr   (rd_addr),
        .res       (scan_res)
    );

    pkcc_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // new count of the hit entry, saturating both ways
    always_comb begin
        if (op_reg == OP_OPEN) begin
            new_count = (scan_res.hit_count == COUNT_MAX) ? scan_res.hit_count
                      : scan_res.hit_count + COUNT_BITS'(1);
        end else begin
            new_count = (scan_res.hit_count == '0) ? '0
                      : scan_res.hit_count - COUNT_BITS'(1);
        end
    end

    assign new_count_ext = CNT_EXT_W'(new_count);

    always_comb begin
        state_next        = state_reg;
        op_next           = op_reg;
        key_next          = key_reg;
        valid_next        = valid_reg;
        m_valid_next      = m_valid_reg;
        m_open_count_next = m_open_count_reg;
        m_status_next     = m_status_reg;
        wr_en             = 1'b0;
        wr_addr           = scan_res.hit_idx;
        wr_data.address   = key_reg;
        wr_data.count     = new_count;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    op_next    = s_op;
                    key_next   = s_client_address;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_res.done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                m_valid_next      = 1'b1;
                m_status_next     = STATUS_OK;
                m_open_count_next = '0;
                if (scan_res.hit) begin
                    wr_en             = 1'b1;
                    m_open_count_next = new_count_ext[OPEN_COUNT_W-1:0];
                    if (op_reg == OP_RELEASE && new_count == '0) begin
                        valid_next[scan_res.hit_idx] = 1'b0;
                    end
                end else if (op_reg == OP_OPEN) begin
                    if (scan_res.free_found) begin
                        wr_en                         = 1'b1;
                        wr_addr                       = scan_res.free_idx;
                        wr_data.count                 = COUNT_BITS'(1);
                        valid_next[scan_res.free_idx] = 1'b1;
                        m_open_count_next             = OPEN_COUNT_W'(1);
                    end else begin
                        m_status_next = STATUS_FULL;
                    end
                end else begin
                    m_status_next = STATUS_UNKNOWN;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg           <= op_next;
        key_reg          <= key_next;
        m_open_count_reg <= m_open_count_next;
        m_status_reg     <= m_status_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_open_count = m_open_count_reg;
    assign m_status     = m_status_reg;

    a_out_only_in_out_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> state_reg == ST_OUT)
        else $error("result beat outside output state");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid_reg))
        else $error("input taken while result pending");

    a_update_gives_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_UPDATE |=> m_valid_reg)
        else $error("update did not produce a result beat");

    a_error_zero_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != STATUS_OK) |-> m_open_count_reg == '0)
        else $error("error status with nonzero count");

    a_scan_done_only_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_res.done |-> state_reg == ST_SCAN)
        else $error("scan finished outside scan state");

endmodule

`default_nettype wire
